[hw/rtl/color_mask_centroid_steering_defines.svh]
// assertion macros used by the checker file
`ifndef COLOR_MASK_CENTROID_STEERING_DEFINES_SVH
`define COLOR_MASK_CENTROID_STEERING_DEFINES_SVH

// condition that must hold in the same cycle as its trigger
`define CMCS_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// condition that must hold in the cycle after its trigger
`define CMCS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cmcs_pkg.sv]
package cmcs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_HUE_LOWER     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HUE_UPPER     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAT_LOWER     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VAL_LOWER     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLUMN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_GAIN    = 3'd6;

  localparam logic [10:0] NEUTRAL_PULSE = 11'd1520;
  localparam logic [10:0] PULSE_MIN     = 11'd1000;
  localparam logic [10:0] PULSE_MAX     = 11'd2000;

  // pulse limits in q8
  localparam int NEUTRAL_Q8    = 1520 * 256;
  localparam int PULSE_MIN_Q8  = 1000 * 256;
  localparam int PULSE_CEIL_Q8 = 2001 * 256;

  typedef struct packed {
    logic [7:0]  hue_lower;
    logic [7:0]  hue_upper;
    logic [7:0]  sat_lower;
    logic [7:0]  val_lower;
    logic [9:0]  line_width;
    logic [8:0]  target_column;
    logic [11:0] steer_gain;
  } cmcs_cfg_t;

  localparam cmcs_cfg_t CFG_RESET = '{
    hue_lower:     8'd20,
    hue_upper:     8'd50,
    sat_lower:     8'd40,
    val_lower:     8'd130,
    line_width:    10'd320,
    target_column: 9'd160,
    steer_gain:    12'd870
  };

endpackage

[hw/rtl/cmcs_if.sv]
interface cmcs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       frame_end;

  modport source (output valid, hue, saturation, brightness, frame_end, input ready);
  modport sink   (input valid, hue, saturation, brightness, frame_end, output ready);
endinterface

interface cmcs_result_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] center_x;
  logic signed [9:0] center_y;
  logic [10:0]       steer_angle;
  logic              found;

  modport source (output valid, center_x, center_y, steer_angle, found, input ready);
  modport sink   (input valid, center_x, center_y, steer_angle, found, output ready);
endinterface

[hw/rtl/cmcs_front.sv]
module cmcs_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int MW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int CSW = CW + MW,
  localparam int RSW = RW + MW,
  localparam int FW  = CSW + RSW + MW
) (
  input  logic                clk,
  input  logic                rst,
  input  cmcs_pkg::cmcs_cfg_t cfg,
  cmcs_pixel_if.sink          pixel,
  input  logic                push_ready,
  output logic                push,
  output logic [FW-1:0]       push_data
);
  import cmcs_pkg::*;

  // wide enough for line_width and for column_count + 1
  localparam int LW = (CW + 1 > 10) ? CW + 1 : 10;

  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [CSW-1:0] column_sum;
  logic [RSW-1:0] row_sum;
  logic [MW-1:0]  mask_count;

  logic [CSW-1:0] column_sum_next;
  logic [RSW-1:0] row_sum_next;
  logic [MW-1:0]  mask_count_next;
  logic [LW-1:0]  line_w;
  logic [LW-1:0]  width_eff;
  logic [LW-1:0]  column_plus;
  logic           hit;
  logic           take;
  logic           accept;

  assign pixel.ready = push_ready;
  assign accept      = pixel.valid && pixel.ready;

  always_comb begin
    line_w = LW'(cfg.line_width);
    priority if (line_w == '0) begin
      width_eff = LW'(1);
    end else if (line_w > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end else begin
      width_eff = line_w;
    end
    column_plus = LW'(column_count) + LW'(1);

    hit = (pixel.hue >= cfg.hue_lower) && (pixel.hue <= cfg.hue_upper) &&
          (pixel.saturation >= cfg.sat_lower) && (pixel.brightness >= cfg.val_lower);
    // sums freeze once the count is full
    take = hit && (mask_count < MW'(MAX_WIDTH * MAX_HEIGHT));

    column_sum_next = column_sum;
    row_sum_next    = row_sum;
    mask_count_next = mask_count;
    if (take) begin
      column_sum_next = column_sum + CSW'(column_count);
      row_sum_next    = row_sum + RSW'(row_count);
      mask_count_next = mask_count + MW'(1);
    end
  end

  assign push      = accept && pixel.frame_end;
  assign push_data = {column_sum_next, row_sum_next, mask_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      column_sum   <= '0;
      row_sum      <= '0;
      mask_count   <= '0;
    end else if (accept) begin
      if (pixel.frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        column_sum   <= '0;
        row_sum      <= '0;
        mask_count   <= '0;
      end else begin
        column_sum <= column_sum_next;
        row_sum    <= row_sum_next;
        mask_count <= mask_count_next;
        if (column_plus >= width_eff) begin
          column_count <= '0;
          if (row_count < RW'(MAX_HEIGHT - 1)) begin
            row_count <= row_count + RW'(1);
          end
        end else begin
          column_count <= column_plus[CW-1:0];
        end
      end
    end
  end

endmodule

[hw/rtl/cmcs_fifo.sv]
module cmcs_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       fill;

  assign full     = (fill == (AW+1)'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + (AW+1)'(1);
        2'b01:   fill <= fill - (AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/cmcs_div.sv]
module cmcs_div #(
  parameter int DEN_W = 19,
  parameter int QUO_W = 9,
  localparam int NUM_W = DEN_W + QUO_W,
  localparam int SW    = $clog2(QUO_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);
  // restoring division, one quotient bit a cycle; num < den << QUO_W
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] bits;
  logic [DEN_W-1:0] divisor;
  logic [SW-1:0]    steps;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;
  logic [QUO_W:0]   shifted;

  always_comb begin
    trial     = {rem, bits[QUO_W-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = (trial >= {1'b0, divisor});
    shifted   = {bits, fits};
  end

  assign busy = (steps != '0);
  assign quo  = bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= SW'(QUO_W);
    end else if (busy) begin
      steps <= steps - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[NUM_W-1:QUO_W];
      bits    <= num[QUO_W-1:0];
      divisor <= den;
    end else if (busy) begin
      rem  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      bits <= shifted[QUO_W-1:0];
    end
  end

endmodule

[hw/rtl/cmcs_back.sv]
module cmcs_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int MW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int CSW = CW + MW,
  localparam int RSW = RW + MW,
  localparam int FW  = CSW + RSW + MW
) (
  input  logic                clk,
  input  logic                rst,
  input  cmcs_pkg::cmcs_cfg_t cfg,
  input  logic                frame_valid,
  input  logic [FW-1:0]       frame_data,
  output logic                pop,
  cmcs_result_if.source       result
);
  import cmcs_pkg::*;

  localparam int DW = ((CW > 9) ? CW : 9) + 1;
  localparam int PW = 13 + DW;
  localparam int QW = ((PW > 20) ? PW : 20) + 1;
  localparam int XW = (CW > 10) ? CW : 10;
  localparam int YW = (RW > 10) ? RW : 10;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  localparam logic signed [QW-1:0] NEUTRAL_Q8_S = QW'(NEUTRAL_Q8);
  localparam logic signed [QW-1:0] MIN_Q8_S     = QW'(PULSE_MIN_Q8);
  localparam logic signed [QW-1:0] CEIL_Q8_S    = QW'(PULSE_CEIL_Q8);

  logic [1:0]           state;
  logic                 out_valid;
  logic                 found_q;
  logic signed [PW-1:0] product;
  logic signed [9:0]    out_x;
  logic signed [9:0]    out_y;
  logic [10:0]          out_angle;
  logic                 out_found;

  logic [CSW-1:0]       column_sum_in;
  logic [RSW-1:0]       row_sum_in;
  logic [MW-1:0]        count_in;
  logic                 found_in;
  logic                 div_start;
  logic                 x_busy;
  logic                 y_busy;
  logic [CW-1:0]        cx;
  logic [RW-1:0]        cy;
  logic [XW-1:0]        cx_ext;
  logic [YW-1:0]        cy_ext;
  logic signed [DW-1:0] diff;
  logic signed [12:0]   gain_s;
  logic signed [QW-1:0] prod_ext;
  logic signed [QW-1:0] q8;
  logic [10:0]          angle;
  logic                 send;

  assign column_sum_in = frame_data[FW-1 -: CSW];
  assign row_sum_in    = frame_data[MW+RSW-1 -: RSW];
  assign count_in      = frame_data[MW-1:0];
  assign found_in      = (count_in > MW'(1));

  assign pop       = (state == ST_IDLE) && frame_valid;
  assign div_start = pop && found_in;

  cmcs_div #(.DEN_W(MW), .QUO_W(CW)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (column_sum_in),
    .den   (count_in),
    .busy  (x_busy),
    .quo   (cx)
  );

  cmcs_div #(.DEN_W(MW), .QUO_W(RW)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (row_sum_in),
    .den   (count_in),
    .busy  (y_busy),
    .quo   (cy)
  );

  always_comb begin
    cx_ext   = XW'(cx);
    cy_ext   = YW'(cy);
    diff     = $signed({{(DW-9){1'b0}}, cfg.target_column}) - $signed({{(DW-CW){1'b0}}, cx});
    gain_s   = $signed({1'b0, cfg.steer_gain});
    prod_ext = product;
    q8       = NEUTRAL_Q8_S + prod_ext;
    priority if (q8 < MIN_Q8_S) begin
      angle = PULSE_MIN;
    end else if (q8 >= CEIL_Q8_S) begin
      angle = PULSE_MAX;
    end else begin
      angle = q8[18:8];
    end
  end

  assign send = (state == ST_SEND) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frame_valid) begin
            state <= found_in ? ST_DIV : ST_SEND;
          end
        end
        ST_DIV: begin
          if (!x_busy && !y_busy) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (send) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found_q <= found_in;
    end
    if ((state == ST_DIV) && !x_busy && !y_busy) begin
      product <= gain_s * diff;
    end
    if (send) begin
      if (found_q) begin
        out_x     <= $signed(cx_ext[9:0]);
        out_y     <= $signed(cy_ext[9:0]);
        out_angle <= angle;
        out_found <= 1'b1;
      end else begin
        out_x     <= -10'sd1;
        out_y     <= -10'sd1;
        out_angle <= NEUTRAL_PULSE;
        out_found <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.center_x    = out_x;
  assign result.center_y    = out_y;
  assign result.steer_angle = out_angle;
  assign result.found       = out_found;

endmodule

[hw/rtl/color_mask_centroid_steering.sv]
// hsv colour-mask centroid and steering: takes one hsv pixel a clock in raster order and, on
// the beat that carries frame_end, queues the frame's column sum, row sum and mask count;
// a back end divides them with two shift-subtract dividers, one quotient bit per cycle;
// two finished frames may wait in the queue and pixel input only stalls when both slots are
// taken; configuration writes are registered and are meant for when the block is idle
module color_mask_centroid_steering #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cmcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  cmcs_pixel_if.sink                       pixel,
  cmcs_result_if.source                    result
);
  import cmcs_pkg::*;

  // widths of the frame summary that crosses the queue
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int MW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int FW  = (CW + MW) + (RW + MW) + MW;

  cmcs_cfg_t     cfg;

  // front to queue
  logic          push;
  logic [FW-1:0] push_data;
  logic          queue_full;

  // queue to back
  logic          pop;
  logic [FW-1:0] pop_data;
  logic          queue_empty;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HUE_LOWER:     cfg.hue_lower     <= cfg_data[7:0];
        REG_HUE_UPPER:     cfg.hue_upper     <= cfg_data[7:0];
        REG_SAT_LOWER:     cfg.sat_lower     <= cfg_data[7:0];
        REG_VAL_LOWER:     cfg.val_lower     <= cfg_data[7:0];
        REG_LINE_WIDTH:    cfg.line_width    <= cfg_data[9:0];
        REG_TARGET_COLUMN: cfg.target_column <= cfg_data[8:0];
        REG_STEER_GAIN:    cfg.steer_gain    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // front: mask test, raster position and running sums, one pixel a beat
  cmcs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel      (pixel),
    .push_ready (!queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // two-deep queue of finished frame summaries
  cmcs_fifo #(.DATA_W(FW), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // back: centroid division, steering multiply and clamp, result register
  cmcs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (!queue_empty),
    .frame_data  (pop_data),
    .pop         (pop),
    .result      (result)
  );

endmodule

[hw/rtl/cmcs_checker.sv]
`include "color_mask_centroid_steering_defines.svh"

module cmcs_checker (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic signed [9:0] center_x,
  input logic signed [9:0] center_y,
  input logic [10:0]       steer_angle,
  input logic              found
);

  // a stalled result beat holds
  `CMCS_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(center_x) && $stable(center_y) && $stable(steer_angle) && $stable(found), "result changed while stalled")

  // nothing found gives the fixed answer
  `CMCS_ASSERT_IMPL(a_not_found, valid && !found, center_x == -10'sd1 && center_y == -10'sd1 && steer_angle == 11'd1520, "bad not-found result")

  // steering pulse stays clamped
  `CMCS_ASSERT_IMPL(a_clamp, valid && found, steer_angle >= 11'd1000 && steer_angle <= 11'd2000, "steer pulse out of range")

  // no result straight out of reset
  `CMCS_ASSERT_IMPL(a_reset, $past(rst), !valid, "result valid after reset")

endmodule

bind color_mask_centroid_steering cmcs_checker u_cmcs_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .center_x    (result.center_x),
  .center_y    (result.center_y),
  .steer_angle (result.steer_angle),
  .found       (result.found)
);
